### sv/b94_pkg.sv
// Shared constants, codes and the work descriptor type for the base94 stream codec.
`timescale 1ns / 1ps

package b94_pkg;

    // Default depth of the descriptor queue between front and back end
    localparam int unsigned QUEUE_DEPTH = 4;

    // Symbol alphabet: '!' .. '~'
    localparam logic [7:0]  SYM_OFFSET = 8'd33;
    localparam logic [7:0]  SYM_LAST   = 8'd126;
    localparam logic [6:0]  SYM_BASE   = 7'd94;

    // A block is cut at 13 bits when its low 13 bits exceed this value
    localparam logic [12:0] LIMIT14    = 13'd643;

    // floor(2^16 / 94): quotient estimate is exact or one low for 14-bit values
    localparam logic [9:0]  RECIP_94    = 10'd697;
    localparam int unsigned RECIP_SHIFT = 16;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef enum logic {
        OP_DATA   = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    // One queued unit of work: one or two result words
    typedef struct packed {
        logic        conv;  // val is a block value, emit val%94+33 then val/94+33
        logic        two;   // two result words, else only the first
        logic        err;   // single error word
        logic [15:0] val;   // block value, or {second byte, first byte}
    } desc_t;

endpackage

### sv/b94_front.sv
// Front end: accepts input words, keeps the bit accumulator and queues result descriptors.
`timescale 1ns / 1ps

module b94_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,     // [7:0] data_byte
    input  logic           s_tuser,     // [0] op
    input  logic           q_full,
    output logic           q_push,
    output b94_pkg::desc_t q_desc
);

    b94_pkg::mode_t mode_reg, mode_next;
    logic [21:0]    acc_reg, acc_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic [7:0]     pend_reg, pend_next;

    logic        accept;
    logic        is_finish;
    logic [21:0] enc_ins;
    logic [4:0]  enc_sum;
    logic        enc_cut13;
    logic        sym_ok;
    logic [6:0]  sym_lo;
    logic [6:0]  sym_hi;
    logic [13:0] dec_v;
    logic [21:0] dec_ins;
    logic        dec_cut13;
    logic [4:0]  dec_sum;
    logic        dec_two;
    logic [21:0] fin_ins;

    // Datapath for both modes
    always_comb begin
        is_finish = (s_tuser == b94_pkg::OP_FINISH);

        // encode: append byte, cut 13 or 14 bits
        enc_ins   = acc_reg | (22'(s_tdata) << cnt_reg[3:0]);
        enc_sum   = cnt_reg + 5'd8;
        enc_cut13 = enc_ins[12:0] > b94_pkg::LIMIT14;

        // decode: rebuild value of a symbol pair
        sym_ok    = (s_tdata >= b94_pkg::SYM_OFFSET) && (s_tdata <= b94_pkg::SYM_LAST);
        sym_lo    = 7'(pend_reg - b94_pkg::SYM_OFFSET);
        sym_hi    = 7'(s_tdata - b94_pkg::SYM_OFFSET);
        dec_v     = 14'(sym_lo) + 14'(sym_hi) * 14'(b94_pkg::SYM_BASE);
        dec_ins   = acc_reg | (22'(dec_v) << cnt_reg[2:0]);
        dec_cut13 = dec_v[12:0] > b94_pkg::LIMIT14;
        dec_sum   = cnt_reg + (dec_cut13 ? 5'd13 : 5'd14);
        dec_two   = dec_sum >= 5'd16;

        // decode finish: pending symbol value appended as 8 bits
        fin_ins   = acc_reg | (22'(sym_lo) << cnt_reg[2:0]);
    end

    // Accept, classify, update state
    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        pend_next = pend_reg;
        q_push    = 1'b0;
        q_desc    = '0;
        s_tready  = !q_full;
        accept    = s_tvalid && s_tready;

        if (cfg_wr_en) begin
            mode_next = b94_pkg::mode_t'(cfg_wr_data);
            acc_next  = '0;
            cnt_next  = '0;
            pend_next = '0;
        end else if (accept) begin
            case (mode_reg)
                b94_pkg::MODE_ENCODE: begin
                    if (is_finish) begin
                        if (cnt_reg != 5'd0) begin
                            q_push      = 1'b1;
                            q_desc.conv = 1'b1;
                            q_desc.two  = (acc_reg > 22'd93) || (cnt_reg > 5'd8);
                            q_desc.val  = acc_reg[15:0];
                        end
                        acc_next  = '0;
                        cnt_next  = '0;
                        pend_next = '0;
                    end else if (enc_sum >= 5'd14) begin
                        q_push      = 1'b1;
                        q_desc.conv = 1'b1;
                        q_desc.two  = 1'b1;
                        if (enc_cut13) begin
                            q_desc.val = {3'b000, enc_ins[12:0]};
                            acc_next   = enc_ins >> 13;
                            cnt_next   = enc_sum - 5'd13;
                        end else begin
                            q_desc.val = {2'b00, enc_ins[13:0]};
                            acc_next   = enc_ins >> 14;
                            cnt_next   = enc_sum - 5'd14;
                        end
                    end else begin
                        acc_next = enc_ins;
                        cnt_next = enc_sum;
                    end
                end
                b94_pkg::MODE_DECODE: begin
                    if (is_finish) begin
                        if (pend_reg != 8'd0) begin
                            q_push     = 1'b1;
                            q_desc.val = {8'd0, fin_ins[7:0]};
                        end
                        acc_next  = '0;
                        cnt_next  = '0;
                        pend_next = '0;
                    end else if (!sym_ok) begin
                        // bad symbol: one error word, state kept
                        q_push     = 1'b1;
                        q_desc.err = 1'b1;
                    end else if (pend_reg == 8'd0) begin
                        pend_next = s_tdata;
                    end else begin
                        q_push     = 1'b1;
                        q_desc.two = dec_two;
                        q_desc.val = dec_ins[15:0];
                        pend_next  = '0;
                        if (dec_two) begin
                            acc_next = dec_ins >> 16;
                            cnt_next = dec_sum - 5'd16;
                        end else begin
                            acc_next = dec_ins >> 8;
                            cnt_next = dec_sum - 5'd8;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= b94_pkg::MODE_ENCODE;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            pend_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
        end
    end

endmodule

### sv/b94_queue.sv
// Descriptor queue decoupling the front end from the back end.
`timescale 1ns / 1ps

module b94_queue #(
    parameter int unsigned DEPTH = b94_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  b94_pkg::desc_t push_desc,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output b94_pkg::desc_t pop_desc
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LVL_W = $clog2(DEPTH + 1);

    b94_pkg::desc_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    // Status and head word
    assign full     = (level_reg == LVL_W'(DEPTH));
    assign valid    = (level_reg != '0);
    assign pop_desc = slot_reg[rd_ptr_reg];

    // Pointer and fill level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Slot storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

### sv/b94_back.sv
// Back end: converts block values to symbol pairs and sends result words.
`timescale 1ns / 1ps

module b94_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  b94_pkg::desc_t q_desc,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,     // [7:0] out_byte
    output logic           m_tlast,     // last
    output logic           m_tuser      // [0] error
);

    // Stage 1: descriptor plus quotient estimate
    logic           d1_valid_reg, d1_valid_next;
    b94_pkg::desc_t d1_desc_reg, d1_desc_next;
    logic [7:0]     d1_quo_reg, d1_quo_next;

    // Stage 2: output words
    logic       e_valid_reg, e_valid_next;
    logic [7:0] e_byte0_reg, e_byte0_next;
    logic [7:0] e_byte1_reg, e_byte1_next;
    logic       e_two_reg, e_two_next;
    logic       e_err_reg, e_err_next;
    logic       e_idx_reg, e_idx_next;

    logic [23:0] quo_prod;
    logic [14:0] base_prod;
    logic [14:0] rem_est;
    logic        rem_fix;
    logic [7:0]  rem_val;
    logic [7:0]  quo_val;
    logic        e_done;
    logic        e_free;
    logic        d1_free;

    // Output port
    assign m_tvalid = e_valid_reg;
    assign m_tdata  = e_idx_reg ? e_byte1_reg : e_byte0_reg;
    assign m_tlast  = !e_two_reg || e_idx_reg;
    assign m_tuser  = e_err_reg;

    // Divide by 94: reciprocal estimate, then one correction step
    always_comb begin
        quo_prod  = 24'(q_desc.val[13:0]) * 24'(b94_pkg::RECIP_94);
        base_prod = 15'(d1_quo_reg) * 15'(b94_pkg::SYM_BASE);
        rem_est   = 15'(d1_desc_reg.val[13:0]) - base_prod;
        rem_fix   = rem_est >= 15'(b94_pkg::SYM_BASE);
        rem_val   = rem_fix ? 8'(rem_est - 15'(b94_pkg::SYM_BASE)) : 8'(rem_est);
        quo_val   = d1_quo_reg + 8'(rem_fix);
    end

    // Pipeline flow
    always_comb begin
        e_done  = e_valid_reg && m_tready && m_tlast;
        e_free  = !e_valid_reg || e_done;
        d1_free = !d1_valid_reg || e_free;
        q_pop   = q_valid && d1_free;

        d1_valid_next = d1_valid_reg;
        d1_desc_next  = d1_desc_reg;
        d1_quo_next   = d1_quo_reg;
        if (d1_free) begin
            d1_valid_next = q_valid;
        end
        if (q_pop) begin
            d1_desc_next = q_desc;
            d1_quo_next  = 8'(quo_prod >> b94_pkg::RECIP_SHIFT);
        end

        e_valid_next = e_valid_reg;
        e_byte0_next = e_byte0_reg;
        e_byte1_next = e_byte1_reg;
        e_two_next   = e_two_reg;
        e_err_next   = e_err_reg;
        e_idx_next   = e_idx_reg;
        if (e_free) begin
            e_valid_next = d1_valid_reg;
            e_idx_next   = 1'b0;
            if (d1_valid_reg) begin
                e_two_next = d1_desc_reg.two;
                e_err_next = d1_desc_reg.err;
                if (d1_desc_reg.conv) begin
                    e_byte0_next = rem_val + b94_pkg::SYM_OFFSET;
                    e_byte1_next = quo_val + b94_pkg::SYM_OFFSET;
                end else begin
                    e_byte0_next = d1_desc_reg.val[7:0];
                    e_byte1_next = d1_desc_reg.val[15:8];
                end
            end
        end else if (e_valid_reg && m_tready) begin
            // first word of a pair taken
            e_idx_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_valid_reg <= 1'b0;
            e_valid_reg  <= 1'b0;
            e_idx_reg    <= 1'b0;
        end else begin
            d1_valid_reg <= d1_valid_next;
            e_valid_reg  <= e_valid_next;
            e_idx_reg    <= e_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        d1_desc_reg <= d1_desc_next;
        d1_quo_reg  <= d1_quo_next;
        e_byte0_reg <= e_byte0_next;
        e_byte1_reg <= e_byte1_next;
        e_two_reg   <= e_two_next;
        e_err_reg   <= e_err_next;
    end

endmodule

### sv/base94_stream_codec.sv
// Top level of the base94 stream codec: front end, descriptor queue, back end.
// A result word passes the queue, then the stage 1 and stage 2 registers of the back end.
// Throughput: one result word per cycle on the single output port while m_tready is
// high; input runs ahead by QUEUE_DEPTH descriptors in the queue plus two held in the
// back end before s_tready drops.
// Reset: aresetn low for one edge clears mode to encode, all stream state and all queues.
`timescale 1ns / 1ps

module base94_stream_codec #(
    parameter int unsigned QUEUE_DEPTH = b94_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,  // mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] data_byte
    input  logic       s_tuser,      // [0] op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [7:0] out_byte
    output logic       m_tlast,      // last
    output logic       m_tuser       // [0] error
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    b94_pkg::desc_t q_in_desc;
    b94_pkg::desc_t q_out_desc;

    // Accept and classify
    b94_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_desc      (q_in_desc)
    );

    // Decoupling queue
    b94_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (q_in_desc),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_desc  (q_out_desc)
    );

    // Convert and send
    b94_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_desc   (q_out_desc),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef ASSERT_OFF
    // An error word stands alone and carries a zero byte
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 8'd0)))
        else $error("error word not single or not zero");

    // Second word of a pair is ready right after the first is taken
    a_pair_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("second word of pair missing");

    // The queue is never pushed while full
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("descriptor queue overrun");
`endif

endmodule

### bench/base94_stream_codec_tb.sv
// Self-checking testbench for the base94 stream codec: encode/decode traffic with random stalls.
`timescale 1ns / 1ps

module base94_stream_codec_tb;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned SETTLE       = 20;   // covers latency plus queued words
    localparam int unsigned RAND_PHASES  = 8;
    localparam int unsigned PHASE_WORDS  = 228;
    localparam int unsigned HOLD_CYCLES  = 400;
    // mode per random phase, bit n for phase n
    localparam logic [7:0]  PHASE_MODES  = 8'b1010_0110;

    // One result word as seen on the master side
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       err;
    } codec_word_t;

    // Scoreboard: tracks codec state and the queue of result words still owed
    class codec_scoreboard;
        b94_pkg::mode_t mode;
        logic [21:0]    acc;
        logic [4:0]     nbits;
        logic [7:0]     held_sym;
        codec_word_t    expected_words[$];
        int             fail_count;

        function new();
            fail_count = 0;
            set_mode(b94_pkg::MODE_ENCODE);
        endfunction

        function void clear_stream();
            acc      = '0;
            nbits    = '0;
            held_sym = '0;
        endfunction

        // mode write also drops any stream state
        function void set_mode(b94_pkg::mode_t m);
            mode = m;
            clear_stream();
        endfunction

        function void push(logic [7:0] b, logic last, logic err);
            codec_word_t w;
            w.out_byte = b;
            w.last     = last;
            w.err      = err;
            expected_words = {expected_words, w};
        endfunction

        // emit up to two whole bytes, LSB first
        function void drain_bytes();
            int n;
            n = (nbits >= 5'd16) ? 2 : int'(nbits >> 3);
            for (int i = 0; i < n; i++) begin
                push(acc[7:0], i == n - 1, 1'b0);
                acc   = acc >> 8;
                nbits = nbits - 5'd8;
            end
        endfunction

        // work out the words that one accepted input word causes
        function void note_input(b94_pkg::op_t op, logic [7:0] data);
            int unsigned a, d, hs, blk, v;
            logic [7:0]  sym;
            logic        two;
            d  = 32'(data);
            hs = 32'(held_sym);
            if (mode == b94_pkg::MODE_ENCODE) begin
                if (op == b94_pkg::OP_DATA) begin
                    a     = 32'(acc) | (d << nbits[3:0]);
                    acc   = a[21:0];
                    nbits = nbits + 5'd8;
                    if (nbits >= 5'd14) begin
                        // 13-bit block when the low 13 bits are above the limit
                        if (acc[12:0] > b94_pkg::LIMIT14) begin
                            blk   = 32'(acc[12:0]);
                            acc   = acc >> 13;
                            nbits = nbits - 5'd13;
                        end else begin
                            blk   = 32'(acc[13:0]);
                            acc   = acc >> 14;
                            nbits = nbits - 5'd14;
                        end
                        sym = 8'(blk % 32'(b94_pkg::SYM_BASE) + 32'(b94_pkg::SYM_OFFSET));
                        push(sym, 1'b0, 1'b0);
                        sym = 8'(blk / 32'(b94_pkg::SYM_BASE) + 32'(b94_pkg::SYM_OFFSET));
                        push(sym, 1'b1, 1'b0);
                    end
                end else begin
                    // flush leftover bits as one or two symbols
                    if (nbits != 5'd0) begin
                        a   = 32'(acc);
                        two = (a > 32'd93) || (nbits > 5'd8);
                        sym = 8'(a % 32'(b94_pkg::SYM_BASE) + 32'(b94_pkg::SYM_OFFSET));
                        push(sym, !two, 1'b0);
                        if (two) begin
                            sym = 8'(a / 32'(b94_pkg::SYM_BASE) + 32'(b94_pkg::SYM_OFFSET));
                            push(sym, 1'b1, 1'b0);
                        end
                    end
                    clear_stream();
                end
            end else begin
                if (op == b94_pkg::OP_DATA) begin
                    if (data < b94_pkg::SYM_OFFSET || data > b94_pkg::SYM_LAST) begin
                        // bad symbol: error word, state untouched
                        push(8'h00, 1'b1, 1'b1);
                    end else if (held_sym == 8'd0) begin
                        held_sym = data;
                    end else begin
                        v        = (hs - 32'(b94_pkg::SYM_OFFSET))
                                 + (d - 32'(b94_pkg::SYM_OFFSET)) * 32'(b94_pkg::SYM_BASE);
                        held_sym = '0;
                        a        = 32'(acc) | (v << nbits[2:0]);
                        acc      = a[21:0];
                        nbits    = nbits
                                 + (((v & 32'h1FFF) > 32'(b94_pkg::LIMIT14)) ? 5'd13 : 5'd14);
                        drain_bytes();
                    end
                end else begin
                    // lone pending symbol goes out as 8 bits
                    if (held_sym != 8'd0) begin
                        v     = (hs - 32'(b94_pkg::SYM_OFFSET)) & 32'hFF;
                        a     = 32'(acc) | (v << nbits[2:0]);
                        acc   = a[21:0];
                        nbits = nbits + 5'd8;
                        drain_bytes();
                    end
                    clear_stream();
                end
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            fail_count++;
        endtask

        task check_result(logic [7:0] b, logic last, logic err);
            codec_word_t w;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word %h last %b err %b", b, last, err));
                return;
            end
            w = expected_words.pop_front();
            if (b !== w.out_byte)
                report($sformatf("out_byte %h, want %h", b, w.out_byte));
            if (last !== w.last)
                report($sformatf("last %b, want %b (byte %h)", last, w.last, w.out_byte));
            if (err !== w.err)
                report($sformatf("error %b, want %b (byte %h)", err, w.err, w.out_byte));
        endtask
    endclass

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'h00;  // [7:0] data_byte
    logic       s_tuser     = 1'b0;   // [0] op
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;              // [7:0] out_byte
    logic       m_tlast;              // last
    logic       m_tuser;              // [0] error

    codec_scoreboard sb;
    logic            tx_gaps_on   = 1'b1;
    logic            hold_off_req = 1'b0;
    int unsigned     rx_words     = 0;
    int unsigned     cycle_count  = 0;

    base94_stream_codec u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // 100 MHz clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one word after a random gap; returns at the falling edge after acceptance
    task automatic send_word(input b94_pkg::op_t op, input logic [7:0] data);
        int gap;
        gap = tx_gaps_on ? int'($urandom_range(0, 15)) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = data;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, data);
        @(negedge aclk);
    endtask

    // Stop offering and let every owed word arrive, plus slack for words in flight
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.expected_words.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_mode(input b94_pkg::mode_t m);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(posedge aclk);
        sb.set_mode(m);
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // Receiver: random stalls per word, one long hold-off on request
    initial begin : rx_side
        int w;
        @(posedge aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready     = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            w = (((rx_words / 128) % 3) != 2) ? int'($urandom_range(0, 15)) : 0;
            if (w > 0) begin
                m_tready = 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tlast, m_tuser);
            rx_words++;
            @(negedge aclk);
        end
    end

    // Stimulus
    initial begin : tx_side
        b94_pkg::op_t op;
        logic [7:0]   data;
        int           r;
        int           n;
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Encode straight out of reset: empty finish, one full byte, 13- and 14-bit cuts
        send_word(b94_pkg::OP_FINISH, 8'h5A);
        send_word(b94_pkg::OP_DATA, 8'hFF);
        send_word(b94_pkg::OP_FINISH, 8'hA5);
        send_word(b94_pkg::OP_DATA, 8'h84);      // 644: 13-bit block
        send_word(b94_pkg::OP_DATA, 8'h02);
        send_word(b94_pkg::OP_FINISH, 8'h00);
        send_word(b94_pkg::OP_DATA, 8'h83);      // 643: 14-bit block
        send_word(b94_pkg::OP_DATA, 8'h02);
        send_word(b94_pkg::OP_DATA, 8'h00);      // more than 8 bits held, small value
        send_word(b94_pkg::OP_FINISH, 8'hFF);

        // Decode: empty finish, bad symbols, alphabet ends, both block sizes
        wait_idle();
        write_mode(b94_pkg::MODE_DECODE);
        send_word(b94_pkg::OP_FINISH, 8'hC3);
        send_word(b94_pkg::OP_DATA, 8'h00);
        send_word(b94_pkg::OP_DATA, 8'h20);
        send_word(b94_pkg::OP_DATA, 8'h7F);
        send_word(b94_pkg::OP_DATA, 8'hFF);
        send_word(b94_pkg::OP_DATA, 8'h21);      // '!' '!' -> 0
        send_word(b94_pkg::OP_DATA, 8'h21);
        send_word(b94_pkg::OP_DATA, 8'h7E);      // '~' '~' -> 8835
        send_word(b94_pkg::OP_DATA, 8'h7E);
        send_word(b94_pkg::OP_DATA, 8'h71);      // 'q' then bad symbol mid-pair
        send_word(b94_pkg::OP_DATA, 8'h80);
        send_word(b94_pkg::OP_DATA, 8'h27);      // completes 644
        send_word(b94_pkg::OP_DATA, 8'h35);      // pending symbol flushed by finish
        send_word(b94_pkg::OP_FINISH, 8'h3C);

        // Random phases, mode per phase from PHASE_MODES; writes land on leftover stream state
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            write_mode(b94_pkg::mode_t'(PHASE_MODES[ph]));
            tx_gaps_on = (ph % 3) != 2;
            if (ph == 1)
                hold_off_req = 1'b1;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (ph == 3 && i == PHASE_WORDS / 2)
                    wait_idle();
                data = 8'($urandom_range(0, 255));
                op   = b94_pkg::OP_DATA;
                if (PHASE_MODES[ph] == b94_pkg::MODE_ENCODE) begin
                    if ($urandom_range(0, 15) == 0)
                        op = b94_pkg::OP_FINISH;
                end else begin
                    r = int'($urandom_range(0, 19));
                    if (r == 0)
                        op = b94_pkg::OP_FINISH;
                    else if (r > 1)
                        data = 8'($urandom_range(32'(b94_pkg::SYM_OFFSET),
                                                 32'(b94_pkg::SYM_LAST)));
                end
                send_word(op, data);
            end
        end

        // Drain and settle
        s_tvalid = 1'b0;
        n = 0;
        while (sb.expected_words.size() != 0 && n < 5000) begin
            @(negedge aclk);
            n++;
        end
        repeat (SETTLE) @(negedge aclk);
        if (sb.expected_words.size() != 0)
            sb.report($sformatf("%0d words never arrived", sb.expected_words.size()));

        if (sb.fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
sv/b94_pkg.sv
sv/b94_front.sv
sv/b94_queue.sv
sv/b94_back.sv
sv/base94_stream_codec.sv
bench/base94_stream_codec_tb.sv
